// ----- hw/rtl/pnce_pkg.sv -----
// Package with shared types, constants and the neighbor offset table.
`default_nettype none
package pnce_pkg;

  localparam int unsigned MAX_SIDE   = 64;
  localparam int unsigned SIDE_W     = 7;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned CELL_W     = 18;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SLOT_W-1:0] HALF_LAST_SLOT = 5'd12;
  localparam logic [SLOT_W-1:0] FULL_LAST_SLOT = 5'd25;

  // Configuration register indexes.
  localparam logic REG_CELLS_PER_SIDE = 1'b0;
  localparam logic REG_FULL_SHELL     = 1'b1;

  typedef enum logic [1:0] {
    OFF_MINUS = 2'd0,
    OFF_ZERO  = 2'd1,
    OFF_PLUS  = 2'd2
  } offset_e;

  typedef struct packed {
    offset_e dx;
    offset_e dy;
    offset_e dz;
  } offset_t;

  // The three candidate coordinates along one axis, already wrapped.
  typedef struct packed {
    logic [COORD_W-1:0] minus;
    logic [COORD_W-1:0] zero;
    logic [COORD_W-1:0] plus;
  } axis_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic              err;
    logic              full;
    logic [SIDE_W-1:0] side;
    axis_t             ax;
    axis_t             ay;
    axis_t             az;
  } desc_t;

  function automatic offset_t slot_offset(input logic [SLOT_W-1:0] slot);
    offset_t o;
    case (slot)
      5'd0:  o = '{OFF_PLUS,  OFF_ZERO,  OFF_ZERO};
      5'd1:  o = '{OFF_PLUS,  OFF_PLUS,  OFF_ZERO};
      5'd2:  o = '{OFF_ZERO,  OFF_PLUS,  OFF_ZERO};
      5'd3:  o = '{OFF_MINUS, OFF_PLUS,  OFF_ZERO};
      5'd4:  o = '{OFF_MINUS, OFF_PLUS,  OFF_PLUS};
      5'd5:  o = '{OFF_ZERO,  OFF_PLUS,  OFF_PLUS};
      5'd6:  o = '{OFF_PLUS,  OFF_PLUS,  OFF_PLUS};
      5'd7:  o = '{OFF_MINUS, OFF_ZERO,  OFF_PLUS};
      5'd8:  o = '{OFF_ZERO,  OFF_ZERO,  OFF_PLUS};
      5'd9:  o = '{OFF_PLUS,  OFF_ZERO,  OFF_PLUS};
      5'd10: o = '{OFF_MINUS, OFF_MINUS, OFF_PLUS};
      5'd11: o = '{OFF_ZERO,  OFF_MINUS, OFF_PLUS};
      5'd12: o = '{OFF_PLUS,  OFF_MINUS, OFF_PLUS};
      5'd13: o = '{OFF_MINUS, OFF_ZERO,  OFF_ZERO};
      5'd14: o = '{OFF_PLUS,  OFF_MINUS, OFF_ZERO};
      5'd15: o = '{OFF_ZERO,  OFF_MINUS, OFF_ZERO};
      5'd16: o = '{OFF_MINUS, OFF_MINUS, OFF_ZERO};
      5'd17: o = '{OFF_MINUS, OFF_PLUS,  OFF_MINUS};
      5'd18: o = '{OFF_ZERO,  OFF_PLUS,  OFF_MINUS};
      5'd19: o = '{OFF_PLUS,  OFF_PLUS,  OFF_MINUS};
      5'd20: o = '{OFF_MINUS, OFF_ZERO,  OFF_MINUS};
      5'd21: o = '{OFF_ZERO,  OFF_ZERO,  OFF_MINUS};
      5'd22: o = '{OFF_PLUS,  OFF_ZERO,  OFF_MINUS};
      5'd23: o = '{OFF_MINUS, OFF_MINUS, OFF_MINUS};
      5'd24: o = '{OFF_ZERO,  OFF_MINUS, OFF_MINUS};
      5'd25: o = '{OFF_PLUS,  OFF_MINUS, OFF_MINUS};
      default: o = '{OFF_ZERO, OFF_ZERO, OFF_ZERO};
    endcase
    return o;
  endfunction

  function automatic logic [COORD_W-1:0] axis_pick(input axis_t a, input offset_e d);
    logic [COORD_W-1:0] v;
    case (d)
      OFF_MINUS: v = a.minus;
      OFF_PLUS:  v = a.plus;
      default:   v = a.zero;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/periodic_neighbour_cell_enum_core.sv -----
// Top level of the periodic neighbor cell enumerator.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/s_axis_tready cell_x, cell_y, cell_z
//  m_axis    out        m_axis_tvalid/m_axis_tready neighbour_cell, slot, last, error
//  cfg       in         cfg_we_i (no wait)          cells_per_side, full_shell
//
// Each cell coordinate yields 13 results (half shell) or 26 (full shell), one per
// cycle while the output is not stalled; an out-of-range coordinate yields a single
// flagged result. The back end's slot sequencer paces the results. The first result
// passes through the s1, s2 and output registers after the item reaches the head of
// the queue. Reset returns the side to 3 and selects the half shell. A stall on the
// output freezes the index pipeline only; the front keeps taking transactions until
// the two-entry queue is full.
`default_nettype none
module periodic_neighbour_cell_enum_core
  import pnce_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port.
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [SIDE_W-1:0]   cfg_wdata_i,
  // Input stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,  // cell_x[5:0], cell_y[11:6], cell_z[17:12]
  // Output stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata,  // neighbour_cell[17:0], neighbour_slot[22:18]
  output logic                     m_axis_tlast,
  output logic                     m_axis_tuser   // coord_error[0]
);

  logic [SIDE_W-1:0] side_q;
  logic              full_q;
  logic [SIDE_W-1:0] side_eff;

  desc_t             front_desc;
  desc_t             head;
  logic              push;
  logic              queue_not_full;
  logic              queue_not_empty;
  logic              pop;
  logic [CELL_W-1:0] out_cell;
  logic [SLOT_W-1:0] out_slot;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 7'd3;
      full_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CELLS_PER_SIDE: side_q <= cfg_wdata_i;
        REG_FULL_SHELL:     full_q <= cfg_wdata_i[0];
        default:            side_q <= side_q;
      endcase
    end
  end

  // Sides above the supported maximum behave as the maximum.
  assign side_eff = (side_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_q;

  assign s_axis_tready = queue_not_full;
  assign push          = s_axis_tvalid && queue_not_full;

  pnce_front u_front (
    .cell_x_i (s_axis_tdata[5:0]),
    .cell_y_i (s_axis_tdata[11:6]),
    .cell_z_i (s_axis_tdata[17:12]),
    .side_i   (side_eff),
    .full_i   (full_q),
    .desc_o   (front_desc)
  );

  pnce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_desc),
    .not_full_o  (queue_not_full),
    .pop_i       (pop),
    .not_empty_o (queue_not_empty),
    .head_o      (head)
  );

  pnce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (queue_not_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_cell_o   (out_cell),
    .out_slot_o   (out_slot),
    .out_last_o   (m_axis_tlast),
    .out_err_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_slot, out_cell};

  // An error result is a lone, empty, final transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("error result not a single empty final transaction");

  // A normal run ends on the last slot of the half or the full shell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser |->
      (m_axis_tdata[22:18] == HALF_LAST_SLOT) || (m_axis_tdata[22:18] == FULL_LAST_SLOT))
    else $error("run ended on an unexpected slot");

  // Inside a run the next result is always already in the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a run of results");

  // The queue is popped only when it holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> queue_not_empty)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

// ----- hw/rtl/pnce_front.sv -----
// Front end: range check and periodic wrap of an incoming cell coordinate.
`default_nettype none
module pnce_front
  import pnce_pkg::*;
(
  input  wire logic [COORD_W-1:0] cell_x_i,
  input  wire logic [COORD_W-1:0] cell_y_i,
  input  wire logic [COORD_W-1:0] cell_z_i,
  input  wire logic [SIDE_W-1:0]  side_i,
  input  wire logic               full_i,
  output desc_t                   desc_o
);

  function automatic axis_t wrap_axis(input logic [COORD_W-1:0] c,
                                      input logic [SIDE_W-1:0]  s);
    axis_t a;
    logic [SIDE_W-1:0] inc;
    inc     = {1'b0, c} + 7'd1;
    a.zero  = c;
    a.minus = (c == '0) ? COORD_W'(s - 7'd1) : c - 6'd1;
    a.plus  = (inc == s) ? '0 : inc[COORD_W-1:0];
    return a;
  endfunction

  always_comb begin
    desc_o.err  = ({1'b0, cell_x_i} >= side_i) || ({1'b0, cell_y_i} >= side_i) ||
                  ({1'b0, cell_z_i} >= side_i);
    desc_o.full = full_i;
    desc_o.side = side_i;
    desc_o.ax   = wrap_axis(cell_x_i, side_i);
    desc_o.ay   = wrap_axis(cell_y_i, side_i);
    desc_o.az   = wrap_axis(cell_z_i, side_i);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pnce_queue.sv -----
// Short queue of classified items between the front and the back.
`default_nettype none
module pnce_queue
  import pnce_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire desc_t push_data_i,
  output logic       not_full_o,
  input  wire logic  pop_i,
  output logic       not_empty_o,
  output desc_t      head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign not_full_o  = (count_q != CNT_W'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pnce_back.sv -----
// Back end: slot sequencer and index pipeline with the output register.
`default_nettype none
module pnce_back
  import pnce_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  wire desc_t              head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CELL_W-1:0]       out_cell_o,
  output logic [SLOT_W-1:0]       out_slot_o,
  output logic                    out_last_o,
  output logic                    out_err_o
);

  localparam int unsigned P1_W = 2 * COORD_W;

  logic              adv;
  logic              issue;
  logic              last_slot;
  logic [SLOT_W-1:0] slot_q, slot_d;
  offset_t           off;
  logic [COORD_W-1:0] nx, ny, nz;
  logic [COORD_W+SIDE_W-1:0] mul1;
  logic [P1_W+SIDE_W-1:0]    mul2;

  logic                s1_valid_q, s2_valid_q, out_valid_q;
  logic [P1_W-1:0]     s1_prod_q;
  logic [COORD_W-1:0]  s1_ny_q, s1_nz_q, s2_nz_q;
  logic [SIDE_W-1:0]   s1_side_q;
  logic [CELL_W-1:0]   s2_prod_q;
  logic [SLOT_W-1:0]   s1_slot_q, s2_slot_q, out_slot_q;
  logic                s1_last_q, s2_last_q, out_last_q;
  logic                s1_err_q, s2_err_q, out_err_q;
  logic [CELL_W-1:0]   out_cell_q;

  // The whole pipeline moves together whenever the output register frees up.
  assign adv       = !out_valid_q || out_ready_i;
  assign issue     = adv && head_valid_i;
  assign last_slot = head_i.err ||
                     (slot_q == (head_i.full ? FULL_LAST_SLOT : HALF_LAST_SLOT));
  assign pop_o     = issue && last_slot;
  assign slot_d    = issue ? (last_slot ? '0 : slot_q + 5'd1) : slot_q;

  assign off  = slot_offset(slot_q);
  assign nx   = axis_pick(head_i.ax, off.dx);
  assign ny   = axis_pick(head_i.ay, off.dy);
  assign nz   = axis_pick(head_i.az, off.dz);
  assign mul1 = {{SIDE_W{1'b0}}, nx} * {{COORD_W{1'b0}}, head_i.side};
  assign mul2 = {{SIDE_W{1'b0}}, s1_prod_q + {{COORD_W{1'b0}}, s1_ny_q}} *
                {{P1_W{1'b0}}, s1_side_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (adv) begin
        s1_valid_q  <= issue;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q  <= mul1[P1_W-1:0];
      s1_ny_q    <= ny;
      s1_nz_q    <= nz;
      s1_side_q  <= head_i.side;
      s1_slot_q  <= head_i.err ? '0 : slot_q;
      s1_last_q  <= last_slot;
      s1_err_q   <= head_i.err;
      s2_prod_q  <= mul2[CELL_W-1:0];
      s2_nz_q    <= s1_nz_q;
      s2_slot_q  <= s1_slot_q;
      s2_last_q  <= s1_last_q;
      s2_err_q   <= s1_err_q;
      out_cell_q <= s2_err_q ? '0 : s2_prod_q + {{(CELL_W-COORD_W){1'b0}}, s2_nz_q};
      out_slot_q <= s2_slot_q;
      out_last_q <= s2_last_q;
      out_err_q  <= s2_err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_cell_o  = out_cell_q;
  assign out_slot_o  = out_slot_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

endmodule
`default_nettype wire
